// ----- rtl/affine_2d_transform_unit_defines.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the affine 2D transform unit
// Shared clocked assertion forms, compiled out under SYNTHESIS.
// ---------------------------------------------------------------------------
`ifndef AFFINE_2D_TRANSFORM_UNIT_DEFINES_SVH
`define AFFINE_2D_TRANSFORM_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define A2D_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("a2d assertion failed");
`define A2D_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("a2d implication failed");
`else
`define A2D_ASSERT(lbl, prop)
`define A2D_ASSERT_IMP(lbl, ante, cons)
`endif
`endif

// ----- rtl/a2d_pkg.sv -----
// ---------------------------------------------------------------------------
// a2d_pkg
// Types, CORDIC constants and helpers for the affine 2D transform unit.
// ---------------------------------------------------------------------------
package a2d_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_CFIN,
        ST_MUL,
        ST_ACC,
        ST_COPY,
        ST_OUT
    } t_state;

    typedef enum logic [2:0] {
        MODE_IDENTITY  = 3'd0,
        MODE_TRANSLATE = 3'd1,
        MODE_ROTATE    = 3'd2,
        MODE_SCALE     = 3'd3,
        MODE_REFLECT   = 3'd4,
        MODE_VERTEX    = 3'd5
    } t_mode;

    localparam int ANG_FRAC = 29;
    localparam logic signed [33:0] CORDIC_GAIN_Q29 = 34'sd326016437;
    localparam logic signed [33:0] PI_Q29          = 34'sd1686629713;
    localparam logic signed [33:0] HALF_PI_Q29     = 34'sd843314856;

    function automatic logic signed [33:0] atan_q29(input logic [4:0] idx);
        logic signed [33:0] v;
        unique case (idx)
            5'd0:  v = 34'sd421657428;
            5'd1:  v = 34'sd248918915;
            5'd2:  v = 34'sd131521918;
            5'd3:  v = 34'sd66762579;
            5'd4:  v = 34'sd33510841;
            5'd5:  v = 34'sd16771758;
            5'd6:  v = 34'sd8387925;
            5'd7:  v = 34'sd4194219;
            5'd8:  v = 34'sd2097141;
            5'd9:  v = 34'sd1048575;
            5'd10: v = 34'sd524288;
            5'd11: v = 34'sd262144;
            5'd12: v = 34'sd131072;
            5'd13: v = 34'sd65536;
            5'd14: v = 34'sd32768;
            5'd15: v = 34'sd16384;
            5'd16: v = 34'sd8192;
            5'd17: v = 34'sd4096;
            5'd18: v = 34'sd2048;
            5'd19: v = 34'sd1024;
            5'd20: v = 34'sd512;
            5'd21: v = 34'sd256;
            5'd22: v = 34'sd128;
            5'd23: v = 34'sd64;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [31:0] r;
        if (v > 68'sh0_0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -68'sh0_0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// ----- rtl/affine_2d_transform_unit.sv -----
// ---------------------------------------------------------------------------
// affine_2d_transform_unit
// Affine composite matrix engine: one shared multiplier under a sequencer.
// ---------------------------------------------------------------------------
// Identity and unused modes are taken while idle; rotate runs the CORDIC first;
//   a vertex also waits in ST_OUT while the output register is still full.
// Each multiply term passes ST_MUL then ST_ACC on the single shared multiplier.
// One item at a time: ready only when the sequencer is idle.
// Synchronous active-low reset: composite returns to identity, no result held.
module affine_2d_transform_unit
    import a2d_pkg::*;
#(
    parameter int FRAC_BITS    = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // val_a[31:0], val_b[63:32], pivot_x[95:64], pivot_y[127:96], angle[143:128]
    input  logic [143:0] i_s_axis_tdata,
    // mode[2:0]
    input  logic [2:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // out_x[31:0], out_y[63:32]
    output logic [63:0]  o_m_axis_tdata
);

    `include "affine_2d_transform_unit_defines.svh"

    localparam int IW = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
    localparam logic signed [31:0] ONE32 = 32'sd1 <<< FRAC_BITS;
    localparam logic signed [32:0] ONE33 = 33'sd1 <<< FRAC_BITS;
    localparam int RSH = ANG_FRAC - FRAC_BITS;

    t_state r_state, n_state;
    logic [2:0] r_mode;
    logic signed [31:0] r_a, r_b, r_px, r_py;
    logic signed [31:0] r_c [6];
    logic signed [31:0] r_m [6];
    logic signed [31:0] r_t [6];
    logic signed [33:0] r_x, r_y, r_z;
    logic [IW-1:0] r_i;
    logic r_neg, r_pm;
    logic [3:0] r_pc;
    logic signed [67:0] r_acc;
    logic r_ov;
    logic [63:0] r_od;

    logic w_mul_en, w_out_free;
    logic signed [32:0] w_op_a, w_op_b;
    logic signed [31:0] w_add;
    logic w_sub, w_last, w_end, w_dest_m;
    logic [2:0] w_dest;
    logic signed [65:0] w_res;
    logic signed [67:0] w_sum, w_fin;
    logic signed [31:0] w_sat;

    a2d_mulq #(.FRAC_BITS(FRAC_BITS)) u_mulq (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_res  (w_res)
    );

    function automatic logic signed [32:0] sx33(input logic signed [31:0] v);
        return {v[31], v};
    endfunction

    // term program: operands, sign, addend and destination per step
    always_comb begin
        logic [2:0] o;
        logic [2:0] rb;
        logic [1:0] cc;
        logic tt;
        o  = r_pc[3:1];
        tt = r_pc[0];
        rb = (o >= 3'd3) ? 3'd3 : 3'd0;
        cc = 2'(o - rb);
        w_op_a = '0; w_op_b = '0; w_add = '0;
        w_sub = 1'b0; w_last = 1'b0; w_end = 1'b0;
        w_dest_m = 1'b0; w_dest = '0;
        if (r_pm) begin
            w_op_a = sx33(r_m[rb + 3'(tt)]);
            w_op_b = sx33(r_c[(tt ? 3'd3 : 3'd0) + 3'(cc)]);
            w_last = tt;
            w_add  = (cc == 2'd2) ? r_m[rb + 3'd2] : '0;
            w_dest = o;
            w_end  = (r_pc == 4'd11);
        end else begin
            priority case (r_mode)
                MODE_ROTATE: begin
                    w_dest_m = 1'b1;
                    unique case (r_pc[1:0])
                        2'd0: begin w_op_a = sx33(r_px); w_op_b = ONE33 - sx33(r_m[0]); end
                        2'd1: begin
                            w_op_a = sx33(r_py); w_op_b = sx33(r_m[3]);
                            w_last = 1'b1; w_dest = 3'd2;
                        end
                        2'd2: begin w_op_a = sx33(r_py); w_op_b = ONE33 - sx33(r_m[0]); end
                        default: begin
                            w_op_a = sx33(r_px); w_op_b = sx33(r_m[3]); w_sub = 1'b1;
                            w_last = 1'b1; w_dest = 3'd5; w_end = 1'b1;
                        end
                    endcase
                end
                MODE_SCALE: begin
                    w_dest_m = 1'b1;
                    w_last   = 1'b1;
                    if (r_pc[0]) begin
                        w_op_a = ONE33 - sx33(r_b); w_op_b = sx33(r_py);
                        w_dest = 3'd5; w_end = 1'b1;
                    end else begin
                        w_op_a = ONE33 - sx33(r_a); w_op_b = sx33(r_px);
                        w_dest = 3'd2;
                    end
                end
                default: begin
                    unique case (r_pc[1:0])
                        2'd0: begin w_op_a = sx33(r_c[0]); w_op_b = sx33(r_a); end
                        2'd1: begin
                            w_op_a = sx33(r_c[1]); w_op_b = sx33(r_b);
                            w_last = 1'b1; w_add = r_c[2]; w_dest = 3'd0;
                        end
                        2'd2: begin w_op_a = sx33(r_c[3]); w_op_b = sx33(r_a); end
                        default: begin
                            w_op_a = sx33(r_c[4]); w_op_b = sx33(r_b);
                            w_last = 1'b1; w_add = r_c[5]; w_dest = 3'd1; w_end = 1'b1;
                        end
                    endcase
                end
            endcase
        end
    end

    assign w_sum = r_acc + (w_sub ? -68'(w_res) : 68'(w_res));
    assign w_fin = w_sum + 68'(w_add);
    assign w_sat = sat32(w_fin);
    assign w_out_free = !r_ov || i_m_axis_tready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    priority case (i_s_axis_tuser)
                        MODE_TRANSLATE, MODE_SCALE, MODE_REFLECT, MODE_VERTEX:
                            n_state = ST_MUL;
                        MODE_ROTATE: n_state = ST_CORDIC;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_CORDIC: if (r_i == IW'(CORDIC_STEPS - 1)) n_state = ST_CFIN;
            ST_CFIN:   n_state = ST_MUL;
            ST_MUL:    n_state = ST_ACC;
            ST_ACC: begin
                if (!w_end)
                    n_state = ST_MUL;
                else if (r_pm)
                    n_state = ST_COPY;
                else if (r_mode == MODE_VERTEX)
                    n_state = ST_OUT;
                else
                    n_state = ST_MUL;
            end
            ST_COPY: n_state = ST_IDLE;
            ST_OUT:  if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        w_mul_en        = (r_state == ST_MUL);
    end

    always_ff @(posedge i_clk) begin
        logic signed [33:0] z0, xf, yf;
        logic signed [67:0] xr, yr;
        z0 = 34'(signed'(i_s_axis_tdata[143:128])) <<< (ANG_FRAC - 13);
        xf = r_neg ? -r_x : r_x;
        yf = r_neg ? -r_y : r_y;
        xr = (68'(xf) + (68'sd1 <<< (RSH - 1))) >>> RSH;
        yr = (68'(yf) + (68'sd1 <<< (RSH - 1))) >>> RSH;
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ov    <= 1'b0;
            r_pm    <= 1'b0;
            r_pc    <= '0;
            r_i     <= '0;
            r_acc   <= '0;
            r_c[0] <= ONE32; r_c[1] <= '0; r_c[2] <= '0;
            r_c[3] <= '0; r_c[4] <= ONE32; r_c[5] <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && w_out_free)
                r_ov <= 1'b1;
            else if (r_ov && i_m_axis_tready)
                r_ov <= 1'b0;
            unique case (r_state)
                ST_IDLE: begin
                    r_pc  <= '0;
                    r_i   <= '0;
                    r_acc <= '0;
                    if (i_s_axis_tvalid) begin
                        r_mode <= i_s_axis_tuser;
                        r_a  <= i_s_axis_tdata[31:0];
                        r_b  <= i_s_axis_tdata[63:32];
                        r_px <= i_s_axis_tdata[95:64];
                        r_py <= i_s_axis_tdata[127:96];
                        r_pm <= (i_s_axis_tuser == MODE_TRANSLATE) ||
                                (i_s_axis_tuser == MODE_REFLECT);
                        priority case (i_s_axis_tuser)
                            MODE_IDENTITY: begin
                                r_c[0] <= ONE32; r_c[1] <= '0; r_c[2] <= '0;
                                r_c[3] <= '0; r_c[4] <= ONE32; r_c[5] <= '0;
                            end
                            MODE_TRANSLATE: begin
                                r_m[0] <= ONE32; r_m[1] <= '0;
                                r_m[2] <= i_s_axis_tdata[31:0];
                                r_m[3] <= '0; r_m[4] <= ONE32;
                                r_m[5] <= i_s_axis_tdata[63:32];
                            end
                            MODE_ROTATE: begin
                                r_x <= CORDIC_GAIN_Q29;
                                r_y <= '0;
                                if (z0 > HALF_PI_Q29) begin
                                    r_z <= z0 - PI_Q29; r_neg <= 1'b1;
                                end else if (z0 < -HALF_PI_Q29) begin
                                    r_z <= z0 + PI_Q29; r_neg <= 1'b1;
                                end else begin
                                    r_z <= z0; r_neg <= 1'b0;
                                end
                            end
                            MODE_SCALE: begin
                                r_m[0] <= i_s_axis_tdata[31:0]; r_m[1] <= '0;
                                r_m[2] <= '0; r_m[3] <= '0;
                                r_m[4] <= i_s_axis_tdata[63:32]; r_m[5] <= '0;
                            end
                            MODE_REFLECT: begin
                                r_m[0] <= -ONE32; r_m[1] <= ONE32 <<< 1; r_m[2] <= '0;
                                r_m[3] <= '0; r_m[4] <= ONE32; r_m[5] <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_CORDIC: begin
                    if (!r_z[33]) begin
                        r_x <= r_x - (r_y >>> r_i);
                        r_y <= r_y + (r_x >>> r_i);
                        r_z <= r_z - atan_q29(5'(r_i));
                    end else begin
                        r_x <= r_x + (r_y >>> r_i);
                        r_y <= r_y - (r_x >>> r_i);
                        r_z <= r_z + atan_q29(5'(r_i));
                    end
                    r_i <= r_i + 1'b1;
                end
                ST_CFIN: begin
                    r_m[0] <= sat32(xr);
                    r_m[4] <= sat32(xr);
                    r_m[3] <= sat32(yr);
                    r_m[1] <= sat32(-68'(sat32(yr)));
                    r_pc   <= '0;
                end
                ST_ACC: begin
                    if (w_last) begin
                        r_acc <= '0;
                        if (w_dest_m) r_m[w_dest] <= w_sat;
                        else          r_t[w_dest] <= w_sat;
                    end else begin
                        r_acc <= w_sum;
                    end
                    if (w_end && !r_pm && r_mode != MODE_VERTEX) begin
                        r_pm <= 1'b1;
                        r_pc <= '0;
                    end else begin
                        r_pc <= r_pc + 1'b1;
                    end
                end
                ST_COPY: begin
                    for (int k = 0; k < 6; k++) r_c[k] <= r_t[k];
                end
                ST_OUT: begin
                    if (w_out_free) r_od <= {r_t[1], r_t[0]};
                end
                default: ;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = r_od;

    `A2D_ASSERT_IMP(a_ov_from_out, $rose(r_ov), $past(r_state) == ST_OUT)
    `A2D_ASSERT_IMP(a_cordic_idx, r_state == ST_CORDIC, 32'(r_i) <= CORDIC_STEPS - 1)
    `A2D_ASSERT_IMP(a_pc_range, r_state == ST_ACC && r_pm, r_pc <= 4'd11)
    `A2D_ASSERT_IMP(a_acc_clear, r_state == ST_CFIN, r_acc == '0)

endmodule

// ----- rtl/a2d_mulq.sv -----
// ---------------------------------------------------------------------------
// a2d_mulq
// Shared signed multiplier with round-half-up to FRAC_BITS, registered.
// ---------------------------------------------------------------------------
module a2d_mulq #(
    parameter int FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [32:0] i_op_a,
    input  logic signed [32:0] i_op_b,
    output logic signed [65:0] o_res
);

    logic signed [65:0] r_res;
    logic signed [65:0] w_prod;

    assign w_prod = (i_op_a * i_op_b) + (66'sd1 <<< (FRAC_BITS - 1));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= w_prod >>> FRAC_BITS;
        end
    end

    assign o_res = r_res;

endmodule

// ----- tb/sv/tb_affine_2d_transform_unit.sv -----
// ---------------------------------------------------------------------------
// Testbench for affine_2d_transform_unit
// Streams mode items (identity, translate, rotate, scale, reflect, vertex and
// unused modes) with random idling on both sides. A local bit-accurate
// predictor tracks the composite matrix and queues the expected vertex
// results, which are checked field by field as they come out.
// ---------------------------------------------------------------------------
module tb_affine_2d_transform_unit;
    import a2d_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC  = 16;
    localparam int          STEPS = 16;
    localparam longint      ONE   = 64'sd1 << FRAC;
    localparam int          LIMIT = 1_000_000;
    localparam logic [2:0]  MODE_SPARE_LO = 3'd6;
    localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
    localparam longint      GAIN_Q29 = 326016437;
    localparam longint      PI_Q29v  = 1686629713;
    localparam longint      HPI_Q29  = 843314856;
    localparam longint      ATAN_TBL [16] = '{
        421657428, 248918915, 131521918, 66762579, 33510841, 16771758, 8387925, 4194219,
        2097141, 1048575, 524288, 262144, 131072, 65536, 32768, 16384};

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_valid = 1'b0;
    logic         s_ready;
    logic [143:0] s_data = '0;
    logic [2:0]   s_mode = '0;
    logic         m_valid;
    logic         m_ready = 1'b0;
    logic [63:0]  m_data;

    affine_2d_transform_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tuser(s_mode),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready), .o_m_axis_tdata(m_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    longint      mat [6];
    logic [31:0] vert_x_q [$];
    logic [31:0] vert_y_q [$];
    int          n_errors = 0;
    int          n_cycles = 0;
    bit          gaps_on = 1'b1;

    function automatic longint clamp32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
    endfunction

    function automatic void load_identity();
        mat = '{ONE, 0, 0, 0, ONE, 0};
    endfunction

    function automatic void apply_left(input longint m [6]);
        longint t [6];
        longint acc;
        for (int r = 0; r < 2; r++) begin
            for (int c = 0; c < 3; c++) begin
                acc = qmul(m[r*3], mat[c]) + qmul(m[r*3+1], mat[3+c]);
                if (c == 2) acc += m[r*3+2];
                t[r*3+c] = clamp32(acc);
            end
        end
        mat = t;
    endfunction

    function automatic void sin_cos(input logic signed [15:0] ang,
                                    output longint cv, output longint sv);
        longint z, x, y, dx, dy;
        bit flip;
        z = longint'(ang) * 65536;
        x = GAIN_Q29;
        y = 0;
        flip = 1'b0;
        if (z > HPI_Q29) begin
            z -= PI_Q29v; flip = 1'b1;
        end else if (z < -HPI_Q29) begin
            z += PI_Q29v; flip = 1'b1;
        end
        for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
                x -= dx; y += dy; z -= ATAN_TBL[i];
            end else begin
                x += dx; y -= dy; z += ATAN_TBL[i];
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        cv = clamp32((x + (64'sd1 <<< 12)) >>> 13);
        sv = clamp32((y + (64'sd1 <<< 12)) >>> 13);
    endfunction

    function automatic void predict_item(input logic [2:0] mode, input logic [143:0] d);
        longint a, b, px, py, cv, sv;
        longint m [6];
        a  = longint'($signed(d[31:0]));
        b  = longint'($signed(d[63:32]));
        px = longint'($signed(d[95:64]));
        py = longint'($signed(d[127:96]));
        case (mode)
            MODE_IDENTITY: load_identity();
            MODE_TRANSLATE: begin
                m = '{ONE, 0, a, 0, ONE, b};
                apply_left(m);
            end
            MODE_ROTATE: begin
                sin_cos(d[143:128], cv, sv);
                m = '{cv, clamp32(-sv), clamp32(qmul(px, ONE - cv) + qmul(py, sv)),
                      sv, cv, clamp32(qmul(py, ONE - cv) - qmul(px, sv))};
                apply_left(m);
            end
            MODE_SCALE: begin
                m = '{a, 0, clamp32(qmul(ONE - a, px)), 0, b, clamp32(qmul(ONE - b, py))};
                apply_left(m);
            end
            MODE_REFLECT: begin
                m = '{-ONE, 2 * ONE, 0, 0, ONE, 0};
                apply_left(m);
            end
            MODE_VERTEX: begin
                vert_x_q.push_back(32'(clamp32(qmul(mat[0], a) + qmul(mat[1], b) + mat[2])));
                vert_y_q.push_back(32'(clamp32(qmul(mat[3], a) + qmul(mat[4], b) + mat[5])));
            end
            default: ;
        endcase
    endfunction

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) begin
            if (vert_x_q.size() == 0) begin
                $error("unexpected result x=%h y=%h", m_data[31:0], m_data[63:32]);
                n_errors++;
            end else begin
                if (m_data[31:0] !== vert_x_q[0]) begin
                    $error("out_x expected %h actual %h", vert_x_q[0], m_data[31:0]);
                    n_errors++;
                end
                if (m_data[63:32] !== vert_y_q[0]) begin
                    $error("out_y expected %h actual %h", vert_y_q[0], m_data[63:32]);
                    n_errors++;
                end
                void'(vert_x_q.pop_front());
                void'(vert_y_q.pop_front());
            end
        end
    end

    // receiver stalls
    int stall_left = 0;
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_ready <= 1'b0;
        end else if (gaps_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_item(input logic [2:0] mode, input logic [31:0] a, input logic [31:0] b,
                             input logic [31:0] px, input logic [31:0] py,
                             input logic [15:0] ang);
        int gap;
        gap = (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 10) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_data  <= {ang, py, px, b, a};
        do @(posedge i_clk); while (!s_ready);
        predict_item(mode, {ang, py, px, b, a});
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return 32'h8000_0000;
            2:       return 32'h7FFF_FFFF;
            3, 4:    return 32'($urandom_range(0, 32'h0004_0000)) - 32'h0002_0000;
            default: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 51472) - 25736);
    endfunction

    task automatic send_random(input logic [2:0] mode);
        logic [31:0] a, b;
        a = rand_q();
        b = rand_q();
        if (mode == MODE_SCALE && $urandom_range(0, 3) != 0) begin
            a = 32'($urandom_range(32'h8000, 32'h2_0000));
            b = 32'($urandom_range(32'h8000, 32'h2_0000));
        end
        send_item(mode, a, b, rand_q(), rand_q(), rand_angle());
    endtask

    task automatic test_directed();
        send_item(MODE_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_item(MODE_VERTEX, 32'h0001_8000, 32'hFFFF_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                  16'hFFFF);
        send_item(MODE_TRANSLATE, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0, 0);
        send_item(MODE_VERTEX, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0);
        send_item(MODE_IDENTITY, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(MODE_ROTATE, 0, 0, 32'h0001_0000, 32'h0002_0000, 16'sd25736);
        send_item(MODE_ROTATE, 0, 0, 0, 0, -16'sd25736);
        send_item(MODE_ROTATE, 0, 0, 32'h0003_0000, 0, 16'sd12868);
        send_item(MODE_VERTEX, 32'h0001_0000, 32'h0001_0000, 0, 0, 0);
        send_item(MODE_ROTATE, 0, 0, 0, 32'h7FFF_FFFF, 16'h7FFF);
        send_item(MODE_ROTATE, 0, 0, 32'h8000_0000, 0, 16'h8000);
        send_item(MODE_ROTATE, 0, 0, 0, 0, 16'sd0);
        send_item(MODE_VERTEX, 32'h0010_0000, 32'hFFF0_0000, 0, 0, 0);
        send_item(MODE_IDENTITY, 0, 0, 0, 0, 0);
        send_item(MODE_SCALE, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        send_item(MODE_VERTEX, 32'h0005_0000, 32'h0005_0000, 0, 0, 0);
        send_item(MODE_IDENTITY, 0, 0, 0, 0, 0);
        send_item(MODE_REFLECT, 0, 0, 0, 0, 0);
        send_item(MODE_SPARE_LO, 32'hFFFF_FFFF, 0, 0, 0, 0);
        send_item(MODE_SPARE_HI, 0, 32'hFFFF_FFFF, 0, 0, 0);
        send_item(MODE_VERTEX, 32'h0002_0000, 32'h0003_0000, 0, 0, 0);
        send_item(MODE_IDENTITY, 0, 0, 0, 0, 0);
    endtask

    task automatic test_random(input int n_items);
        int sent;
        int k;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 4) == 0) begin
                send_random(3'($urandom_range(0, 7)));
                sent++;
            end else begin
                send_item(MODE_IDENTITY, $urandom, $urandom, $urandom, $urandom,
                          16'($urandom));
                k = $urandom_range(1, 4);
                repeat (k) send_random(3'($urandom_range(MODE_TRANSLATE, MODE_REFLECT)));
                sent += k + 1;
                k = $urandom_range(1, 4);
                repeat (k) send_random(MODE_VERTEX);
                sent += k;
            end
            if (sent > n_items * 4 / 5) gaps_on = 1'b0;
        end
        s_valid <= 1'b0;
    endtask

    initial begin
        load_identity();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(1500);
        while (vert_x_q.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+rtl
rtl/a2d_pkg.sv
rtl/a2d_mulq.sv
rtl/affine_2d_transform_unit.sv
tb/sv/tb_affine_2d_transform_unit.sv
